// File: rtl/core/vector_cosine_similarity_assert.svh
// Assertion macros for the cosine similarity block.
// Used by the port-level checker; depends on clk_i and rst_ni in scope.
`ifndef VECTOR_COSINE_SIMILARITY_ASSERT_SVH
`define VECTOR_COSINE_SIMILARITY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/vcs_pkg.sv
// Shared constants, state encoding and command struct for the cosine
// similarity block. No dependencies.
package vcs_pkg;

  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned SUM_W       = 44;
  localparam int unsigned ROOT_W      = SUM_W / 2;
  localparam int unsigned SQRT_STEPS  = ROOT_W;
  localparam int unsigned QUO_W       = 17;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned SIM_W       = 16;
  localparam int unsigned CFG_W       = 16;

  localparam logic [SIM_W-1:0] ONE_Q15       = 16'd32768;
  localparam logic [CFG_W-1:0] MIN_DEN_RESET = 16'd1074;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_DIVLD,
    ST_DIV,
    ST_OUT
  } vcs_state_e;

  typedef struct packed {
    logic capture;    // register the products of an accepted pair
    logic clr;        // clear the running sums
    logic sqrt_load;  // load the root units and the dot magnitude
    logic sqrt_step;  // one digit of both roots
    logic den_mul;    // multiply the two roots
    logic div_load;   // set up the divider and the floor check
    logic div_step;   // one quotient bit
    logic out_load;   // load the output register
  } vcs_cmd_t;

endpackage

// File: rtl/core/vcs_datapath.sv
// Datapath of the cosine similarity block: products, saturating sums,
// two digit-serial square roots, denominator multiply and divider. Uses vcs_pkg.
module vcs_datapath import vcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vcs_cmd_t                 cmd_i,
  input  logic signed [ELEM_W-1:0] elem_a_i,
  input  logic signed [ELEM_W-1:0] elem_b_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic [SIM_W-1:0]         similarity_o,
  output logic                     degenerate_o
);

  typedef struct packed {
    logic [SUM_W-1:0]    rad;
    logic [ROOT_W+1:0]   rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_t;

  // One step of the restoring square root: two radicand bits in, one root bit out.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    sqrt_t             r;
    rem_sh = {s.rem, s.rad[SUM_W-1 -: 2]};
    trial  = {2'b00, s.root, 2'b01};
    r.rad  = {s.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = ROOT_W'(0) + (ROOT_W+2)'(rem_sh - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = (ROOT_W+2)'(rem_sh);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [CFG_W-1:0]         min_den_q;
  logic signed [PROD_W-1:0] pd_q;
  logic [PROD_W-1:0]        pa_q, pb_q;
  logic                     pv_q;
  logic [SUM_W-1:0]         dot_q, na_q, nb_q;
  logic [SUM_W-1:0]         mag_q;
  sqrt_t                    sa_q, sb_q;
  logic [SUM_W-1:0]         den_q;
  logic [SUM_W-1:0]         rem_q;
  logic [QUO_W-1:0]         low_q;
  logic [QUO_W-1:0]         quo_q;
  logic                     ovf_q, degen_q;
  logic [SIM_W-1:0]         similarity_q;
  logic                     degenerate_q;

  logic signed [PROD_W-1:0] pd_d, pa_full, pb_full;
  logic [SUM_W:0]           dot_sum, na_sum, nb_sum;
  logic [SUM_W-1:0]         dot_sat, na_sat, nb_sat;
  logic [SUM_W-1:0]         den_d;
  logic [SUM_W+15:0]        num;
  logic [SUM_W:0]           div_r2, div_diff;
  logic                     div_ge;
  logic [SIM_W-1:0]         sim_d;

  assign pd_d    = elem_a_i * elem_b_i;
  assign pa_full = elem_a_i * elem_a_i;
  assign pb_full = elem_b_i * elem_b_i;

  // Saturating accumulation of the registered products.
  assign dot_sum = {dot_q[SUM_W-1], dot_q} + {{(SUM_W+1-PROD_W){pd_q[PROD_W-1]}}, pd_q};
  assign na_sum  = {1'b0, na_q} + {{(SUM_W+1-PROD_W){1'b0}}, pa_q};
  assign nb_sum  = {1'b0, nb_q} + {{(SUM_W+1-PROD_W){1'b0}}, pb_q};

  always_comb begin
    if (dot_sum[SUM_W] != dot_sum[SUM_W-1]) begin
      dot_sat = dot_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      dot_sat = dot_sum[SUM_W-1:0];
    end
    na_sat = na_sum[SUM_W] ? {SUM_W{1'b1}} : na_sum[SUM_W-1:0];
    nb_sat = nb_sum[SUM_W] ? {SUM_W{1'b1}} : nb_sum[SUM_W-1:0];
  end

  assign den_d = SUM_W'(sa_q.root * sb_q.root);

  // Numerator with the half-denominator added for round half up.
  assign num = {1'b0, mag_q, 15'b0} + {17'b0, den_q[SUM_W-1:1]};

  assign div_r2   = {rem_q, low_q[QUO_W-1]};
  assign div_diff = div_r2 - {1'b0, den_q};
  assign div_ge   = div_r2 >= {1'b0, den_q};

  always_comb begin
    priority if (degen_q) begin
      sim_d = '0;
    end else if (ovf_q || quo_q > {1'b0, ONE_Q15}) begin
      sim_d = ONE_Q15;
    end else begin
      sim_d = quo_q[SIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_den_q <= MIN_DEN_RESET;
      pv_q      <= 1'b0;
      dot_q     <= '0;
      na_q      <= '0;
      nb_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        min_den_q <= cfg_wdata_i;
      end
      pv_q <= cmd_i.capture;
      if (cmd_i.clr) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else if (pv_q) begin
        dot_q <= dot_sat;
        na_q  <= na_sat;
        nb_q  <= nb_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pd_q <= pd_d;
      pa_q <= pa_full;
      pb_q <= pb_full;
    end
    if (cmd_i.sqrt_load) begin
      sa_q  <= '{rad: na_q, rem: '0, root: '0};
      sb_q  <= '{rad: nb_q, rem: '0, root: '0};
      mag_q <= dot_q[SUM_W-1] ? (~dot_q + SUM_W'(1)) : dot_q;
    end else if (cmd_i.sqrt_step) begin
      sa_q <= sqrt_step(sa_q);
      sb_q <= sqrt_step(sb_q);
    end
    if (cmd_i.den_mul) begin
      den_q <= den_d;
    end
    if (cmd_i.div_load) begin
      degen_q <= den_q <= {{(SUM_W-CFG_W){1'b0}}, min_den_q};
      ovf_q   <= {1'b0, num[SUM_W+15:QUO_W]} >= den_q;
      rem_q   <= {1'b0, num[SUM_W+15:QUO_W]};
      low_q   <= num[QUO_W-1:0];
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[SUM_W-1:0] : div_r2[SUM_W-1:0];
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      similarity_q <= sim_d;
      degenerate_q <= degen_q;
    end
  end

  assign similarity_o = similarity_q;
  assign degenerate_o = degenerate_q;

endmodule

// File: rtl/core/vcs_ctrl.sv
// Controller of the cosine similarity block: sequences accumulation, the
// roots, the divide and the output transfer. Uses vcs_pkg.
module vcs_ctrl import vcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output vcs_cmd_t cmd_o
);

  vcs_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACC: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && last_i) begin
          state_d = ST_DRAIN;
        end
      end
      // The last product is folded into the sums here.
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.sqrt_load = 1'b1;
        cmd_o.clr       = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.den_mul = 1'b1;
        state_d       = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_OUT;
        end
      end
      // Wait here only while an earlier result has not yet been transferred.
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/vector_cosine_similarity.sv
// Streaming absolute cosine similarity. Throughput: one element pair per cycle
// while accumulating. After the pair marked last, input is held off while the
// block folds the last product, sets up the roots, computes 22 root digits,
// multiplies the roots, sets up the divider, computes 17 quotient bits and loads
// the output register; the output load is held off while the previous result is
// still waiting to be transferred. Reset clears the sums and sets the floor to 1074.
module vector_cosine_similarity import vcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ELEM_W-1:0] elem_a_i,
  input  logic signed [ELEM_W-1:0] elem_b_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SIM_W-1:0]         similarity_o,
  output logic                     degenerate_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i
);

  vcs_cmd_t cmd;

  vcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .out_ready_i(out_ready_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  vcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .similarity_o(similarity_o),
    .degenerate_o(degenerate_o)
  );

endmodule

// File: rtl/core/vcs_checker.sv
// Port-level checker for vector_cosine_similarity, bound to the top level.
// Depends on vcs_pkg and vector_cosine_similarity_assert.svh.
`include "vector_cosine_similarity_assert.svh"

module vcs_checker import vcs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             last_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [SIM_W-1:0] similarity_o,
  input logic             degenerate_o
);

  `VCS_ASSERT_NOW(a_sim_range, out_valid_o, similarity_o <= ONE_Q15, "similarity above one")
  `VCS_ASSERT_NOW(a_degen_zero, out_valid_o && degenerate_o, similarity_o == '0,
                  "degenerate result not zero")
  `VCS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(similarity_o) && $stable(degenerate_o),
                   "output changed while stalled")
  `VCS_ASSERT_NEXT(a_last_stall, in_valid_i && in_ready_o && last_i, !in_ready_o,
                   "input taken during final computation")
  `VCS_ASSERT_NOW(a_result_at_resume, $rose(out_valid_o), in_ready_o,
                  "result appeared outside accumulation")

endmodule

bind vector_cosine_similarity vcs_checker u_vcs_checker (.*);

// File: verif/tb_vector_cosine_similarity.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_cosine_similarity: streams element pairs
// in bursts against a stalling receiver and checks every similarity result.
// Depends on vcs_pkg and the vector_cosine_similarity RTL.
module tb_vector_cosine_similarity import vcs_pkg::*; ();

  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned FULL_VECTOR   = 512;

  localparam longint          DOT_HI  = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint          DOT_LO  = -DOT_HI - 1;
  localparam longint unsigned NORM_HI = (64'd1 << SUM_W) - 64'd1;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic             degenerate;
  } cosine_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ELEM_W-1:0] elem_a_i;
  logic signed [ELEM_W-1:0] elem_b_i;
  logic                     last_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [SIM_W-1:0]         similarity_o;
  logic                     degenerate_o;
  logic                     cfg_we_i;
  logic [CFG_W-1:0]         cfg_wdata_i;

  // Expected results in order, and the predictor's own copy of the sums.
  cosine_result_t  cosine_q[$];
  longint          dot_acc   = 0;
  longint unsigned energy_a  = 0;
  longint unsigned energy_b  = 0;
  logic [CFG_W-1:0] den_floor = MIN_DEN_RESET;

  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left   = 0;
  int unsigned pairs_sent   = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;

  vector_cosine_similarity dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elem_a_i     (elem_a_i),
    .elem_b_i     (elem_b_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .similarity_o (similarity_o),
    .degenerate_o (degenerate_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Floor square root, built one root bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic cosine_result_t cosine_of_sums(longint dot, longint unsigned na,
                                                    longint unsigned nb,
                                                    logic [CFG_W-1:0] flr);
    longint unsigned den;
    longint unsigned mag;
    longint unsigned quo;
    cosine_result_t  r;
    den = floor_root(na) * floor_root(nb);
    if (den <= flr) begin
      r.similarity = '0;
      r.degenerate = 1'b1;
    end else begin
      if (dot < 0) mag = -dot;
      else mag = dot;
      // Round half up; floored roots can push the ratio past one.
      quo = ((mag << 15) + (den >> 1)) / den;
      if (quo > ONE_Q15) quo = ONE_Q15;
      r.similarity = quo[SIM_W-1:0];
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    longint          prod;
    cosine_result_t  want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (cosine_q.size() == 0) begin
          $error("unexpected result: similarity %0d, degenerate %0d",
                 similarity_o, degenerate_o);
          error_count++;
        end else begin
          want = cosine_q.pop_front();
          if (similarity_o !== want.similarity) begin
            $error("similarity: expected %0d, got %0d", want.similarity, similarity_o);
            error_count++;
          end
          if (degenerate_o !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate, degenerate_o);
            error_count++;
          end
        end
      end
      if (cfg_we_i) den_floor = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        prod = longint'(elem_a_i) * longint'(elem_b_i);
        dot_acc = dot_acc + prod;
        if (dot_acc > DOT_HI) dot_acc = DOT_HI;
        if (dot_acc < DOT_LO) dot_acc = DOT_LO;
        energy_a = energy_a + longint'(elem_a_i) * longint'(elem_a_i);
        if (energy_a > NORM_HI) energy_a = NORM_HI;
        energy_b = energy_b + longint'(elem_b_i) * longint'(elem_b_i);
        if (energy_b > NORM_HI) energy_b = NORM_HI;
        if (last_i) begin
          cosine_q.push_back(cosine_of_sums(dot_acc, energy_a, energy_b, den_floor));
          dot_acc  = 0;
          energy_a = 0;
          energy_b = 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[vector_cosine_similarity] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The receiver moves between always ready, coin-toss and mostly stalled
  // phases, and holds off entirely for a long stretch when asked to.
  initial begin : receiver_stalls
    int unsigned phase_left;
    int unsigned mode;
    phase_left = 0;
    mode = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          phase_left = $urandom_range(5, 60);
        end
        phase_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offers one pair and returns at the edge where its transfer takes place.
  task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    elem_a_i   <= a;
    elem_b_i   <= b;
    last_i     <= lst;
    pairs_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cosine_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Corners of the Q1.15 range under the reset floor.
  task automatic test_extreme_pairs();
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(ELEM_MAX, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    // Denominators of 1024, 1089 and 1056 either side of the reset floor.
    send_pair(16'sd32, 16'sd32, 1'b1);
    send_pair(16'sd33, 16'sd33, 1'b1);
    send_pair(16'sd32, 16'sd33, 1'b1);
    send_pair(16'sd1000, -16'sd2000, 1'b0);
    send_pair(16'sd3000, 16'sd500, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    // Orthogonal vectors give zero without being degenerate.
    send_pair(16'sd1000, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1000, 1'b1);
    // The floored roots make this ratio exceed one, so it saturates.
    send_pair(16'sd100, 16'sd100, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
  endtask

  task automatic test_floor_register();
    write_floor('0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    write_floor('1);
    send_pair(16'sd255, 16'sd255, 1'b1);
    send_pair(16'sd256, 16'sd256, 1'b1);
    send_pair(16'sd255, 16'sd257, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    write_floor(16'd500);
  endtask

  // The receiver stalls while short vectors keep arriving, so the block
  // fills up and holds off its input.
  task automatic test_output_backpressure();
    int unsigned len;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    hold_request = 1'b1;
    gaps_on = 1'b0;
    for (int n = 0; n < 24; n++) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) begin
        a = ELEM_W'($urandom);
        b = ELEM_W'($urandom);
        send_pair(a, b, k == len - 1);
      end
    end
    gaps_on = 1'b1;
    wait_for_results();
  endtask

  // Full-length vectors at the Q1.15 limits give the largest sums that a
  // vector of the intended length can reach.
  task automatic test_full_length_vectors();
    for (int k = 0; k < FULL_VECTOR; k++) begin
      send_pair(ELEM_MIN, ELEM_MIN, k == FULL_VECTOR - 1);
    end
    // Products of opposite sign almost cancel pair by pair.
    for (int k = 0; k < FULL_VECTOR; k++) begin
      send_pair(ELEM_MAX, (k % 2 == 0) ? ELEM_MIN : ELEM_MAX, k == FULL_VECTOR - 1);
    end
    wait_for_results();
  endtask

  task automatic test_random_vectors();
    int unsigned len;
    int unsigned mode;
    int unsigned pick;
    int unsigned vectors;
    int unsigned start;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    vectors = 0;
    start = pairs_sent;
    while (pairs_sent - start < RANDOM_ITEMS) begin
      if (vectors % 12 == 11) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: write_floor('0);
          1: write_floor('1);
          2: write_floor(MIN_DEN_RESET);
          3: write_floor(CFG_W'($urandom));
          default: write_floor(CFG_W'($urandom_range(0, 4000)));
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 64);
      else if (pick < 99) len = $urandom_range(65, 256);
      else len = FULL_VECTOR;
      mode = $urandom_range(0, 5);
      for (int k = 0; k < len; k++) begin
        a = ELEM_W'($urandom);
        b = ELEM_W'($urandom);
        case (mode)
          1: b = a ^ ELEM_W'($urandom_range(0, 63));
          2: b = ~a;
          3: begin
            a = ELEM_W'($urandom_range(0, 80));
            a = a - 16'sd40;
            b = ELEM_W'($urandom_range(0, 80));
            b = b - 16'sd40;
          end
          4: begin
            // One side is always zero, so the dot product stays at zero.
            if (k % 2 == 0) b = '0;
            else a = '0;
          end
          5: begin
            a = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
            b = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
          end
          default: ;
        endcase
        send_pair(a, b, k == len - 1);
      end
      vectors++;
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    elem_a_i    <= '0;
    elem_b_i    <= '0;
    last_i      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_pairs();
    test_floor_register();
    test_output_backpressure();
    test_full_length_vectors();
    test_random_vectors();
    wait_for_results();
    if (error_count == 0) begin
      $display("[vector_cosine_similarity] OK");
    end else begin
      $display("[vector_cosine_similarity] ERROR");
    end
    $finish;
  end

endmodule
